@@ hdl/zip64_extra_field_parser_assert.svh @@
// Assertion macros shared by the parser's RTL files.
`ifndef ZIP64_EXTRA_FIELD_PARSER_ASSERT_SVH
`define ZIP64_EXTRA_FIELD_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
`define ZXF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define ZXF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ZXF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ZXF_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ hdl/zxf_pkg.sv @@
`default_nettype none
package zxf_pkg;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_SKIP,
      PH_DATA,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_MALFORMED = 2'd1,
      ST_SHORT     = 2'd2
   } status_type;

   localparam logic [2:0] FLD_UNCOMP = 3'd0;
   localparam logic [2:0] FLD_COMP   = 3'd1;
   localparam logic [2:0] FLD_OFFSET = 3'd2;
   localparam logic [2:0] FLD_DISK   = 3'd3;
   localparam logic [2:0] FLD_NONE   = 3'd4;

   localparam logic [15:0] ZIP64_ID = 16'h0001;
   localparam logic [31:0] SENT32   = 32'hffff_ffff;
   localparam logic [15:0] SENT16   = 16'hffff;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        byte_present;
      logic        last_byte;
      logic [31:0] size_uncomp_short;
      logic [31:0] size_comp_short;
      logic [31:0] local_offset_short;
      logic [15:0] start_disk_short;
   } item_type;

   typedef struct packed {
      logic [63:0] uncomp_size;
      logic [63:0] comp_size;
      logic [63:0] local_offset;
      logic [31:0] start_disk;
      logic        record_found;
      status_type  parse_status;
   } result_type;

   typedef struct packed {
      logic       load;
      result_type result;
   } result_load_type;

endpackage
`default_nettype wire

@@ hdl/zxf_parser.sv @@
`default_nettype none
`include "zip64_extra_field_parser_assert.svh"
module zxf_parser
   import zxf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  item_type   item,
   output result_type result
);

   phase_type   phase_ff, phase_in;
   logic [1:0]  hbi_ff, hbi_in;
   logic [15:0] id_ff, id_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [2:0]  wanted_ff, wanted_in;
   logic [2:0]  fbi_ff, fbi_in;
   logic [63:0] uncomp_ff, uncomp_in;
   logic [63:0] comp_ff, comp_in;
   logic [63:0] offset_ff, offset_in;
   logic [31:0] disk_ff, disk_in;
   logic        short_ff, short_in;

   logic [3:0]  need;
   logic [2:0]  w1;
   logic        field_end;
   logic        found;
   status_type  status;

   // Advance past fields that the header does not ask for, but only between fields.
   function automatic logic [2:0] skip_fields(input logic [2:0] wanted,
                                              input logic [2:0] fbi,
                                              input logic [3:0] need_mask);
      logic [2:0] w;
      w = wanted;
      if (fbi == 3'd0) begin
         for (int k = 0; k < 4; k++) begin
            if (w == 3'(k) && !need_mask[k]) begin
               w = w + 3'd1;
            end
         end
      end
      return w;
   endfunction

   always_comb begin
      phase_in      = phase_ff;
      hbi_in        = hbi_ff;
      id_in         = id_ff;
      bytes_left_in = bytes_left_ff;
      wanted_in     = wanted_ff;
      fbi_in        = fbi_ff;
      uncomp_in     = uncomp_ff;
      comp_in       = comp_ff;
      offset_in     = offset_ff;
      disk_in       = disk_ff;
      short_in      = short_ff;
      w1            = wanted_ff;
      field_end     = 1'b0;

      need[0] = item.size_uncomp_short == SENT32;
      need[1] = item.size_comp_short == SENT32;
      need[2] = item.local_offset_short == SENT32;
      need[3] = item.start_disk_short == SENT16;

      if (fire && item.byte_present) begin
         unique case (phase_ff)
            PH_HEADER: begin
               case (hbi_ff)
                  2'd0: id_in = {8'h00, item.data_byte};
                  2'd1: id_in = {item.data_byte, id_ff[7:0]};
                  2'd2: bytes_left_in = {8'h00, item.data_byte};
                  default: bytes_left_in = {item.data_byte, bytes_left_ff[7:0]};
               endcase
               if (hbi_ff == 2'd3) begin
                  hbi_in = 2'd0;
                  if (id_in == ZIP64_ID) begin
                     if (bytes_left_in == 16'd0) begin
                        wanted_in = skip_fields(wanted_ff, fbi_ff, need);
                        short_in  = wanted_in < FLD_NONE;
                        phase_in  = PH_DONE;
                     end else begin
                        phase_in = PH_DATA;
                     end
                  end else if (bytes_left_in != 16'd0) begin
                     phase_in = PH_SKIP;
                  end
               end else begin
                  hbi_in = hbi_ff + 2'd1;
               end
            end
            PH_SKIP: begin
               bytes_left_in = bytes_left_ff - 16'd1;
               if (bytes_left_in == 16'd0) begin
                  phase_in = PH_HEADER;
               end
            end
            PH_DATA: begin
               w1        = skip_fields(wanted_ff, fbi_ff, need);
               wanted_in = w1;
               if (w1 < FLD_NONE) begin
                  case (w1)
                     FLD_UNCOMP: uncomp_in[{fbi_ff, 3'b000} +: 8] =
                        uncomp_ff[{fbi_ff, 3'b000} +: 8] | item.data_byte;
                     FLD_COMP: comp_in[{fbi_ff, 3'b000} +: 8] =
                        comp_ff[{fbi_ff, 3'b000} +: 8] | item.data_byte;
                     FLD_OFFSET: offset_in[{fbi_ff, 3'b000} +: 8] =
                        offset_ff[{fbi_ff, 3'b000} +: 8] | item.data_byte;
                     default: disk_in[{fbi_ff[1:0], 3'b000} +: 8] =
                        disk_ff[{fbi_ff[1:0], 3'b000} +: 8] | item.data_byte;
                  endcase
                  field_end = (w1 == FLD_DISK) ? (fbi_ff == 3'd3) : (fbi_ff == 3'd7);
                  if (field_end) begin
                     fbi_in    = 3'd0;
                     wanted_in = w1 + 3'd1;
                  end else begin
                     fbi_in = fbi_ff + 3'd1;
                  end
               end
               bytes_left_in = bytes_left_ff - 16'd1;
               if (bytes_left_in == 16'd0) begin
                  wanted_in = skip_fields(wanted_in, fbi_in, need);
                  short_in  = wanted_in < FLD_NONE;
                  phase_in  = PH_DONE;
               end
            end
            default: begin
            end
         endcase
      end

      // The result reflects the state after this word.
      found  = phase_in == PH_DONE;
      status = ST_OK;
      if (found) begin
         status = short_in ? ST_SHORT : ST_OK;
      end else if (phase_in == PH_SKIP || phase_in == PH_DATA || hbi_in != 2'd0) begin
         status = ST_MALFORMED;
      end

      result.record_found = found;
      result.parse_status = status;
      if (found && status == ST_OK) begin
         result.uncomp_size  = need[0] ? uncomp_in : {32'd0, item.size_uncomp_short};
         result.comp_size    = need[1] ? comp_in : {32'd0, item.size_comp_short};
         result.local_offset = need[2] ? offset_in : {32'd0, item.local_offset_short};
         result.start_disk   = need[3] ? disk_in : {16'd0, item.start_disk_short};
      end else begin
         result.uncomp_size  = {32'd0, item.size_uncomp_short};
         result.comp_size    = {32'd0, item.size_comp_short};
         result.local_offset = {32'd0, item.local_offset_short};
         result.start_disk   = {16'd0, item.start_disk_short};
      end

      // The last word of a header returns the parser to its starting state.
      if (fire && item.last_byte) begin
         phase_in      = PH_HEADER;
         hbi_in        = 2'd0;
         id_in         = 16'd0;
         bytes_left_in = 16'd0;
         wanted_in     = FLD_UNCOMP;
         fbi_in        = 3'd0;
         uncomp_in     = 64'd0;
         comp_in       = 64'd0;
         offset_in     = 64'd0;
         disk_in       = 32'd0;
         short_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         hbi_ff        <= 2'd0;
         id_ff         <= 16'd0;
         bytes_left_ff <= 16'd0;
         wanted_ff     <= FLD_UNCOMP;
         fbi_ff        <= 3'd0;
         uncomp_ff     <= 64'd0;
         comp_ff       <= 64'd0;
         offset_ff     <= 64'd0;
         disk_ff       <= 32'd0;
         short_ff      <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         hbi_ff        <= hbi_in;
         id_ff         <= id_in;
         bytes_left_ff <= bytes_left_in;
         wanted_ff     <= wanted_in;
         fbi_ff        <= fbi_in;
         uncomp_ff     <= uncomp_in;
         comp_ff       <= comp_in;
         offset_ff     <= offset_in;
         disk_ff       <= disk_in;
         short_ff      <= short_in;
      end
   end

   `ZXF_ASSERT_NEXT(a_last_restarts, clock, reset, fire && item.last_byte, phase_ff == PH_HEADER && hbi_ff == 2'd0 && wanted_ff == FLD_UNCOMP, "parser did not restart after the last word")
   `ZXF_ASSERT_IMPLY(a_count_live, clock, reset, phase_ff == PH_SKIP || phase_ff == PH_DATA, bytes_left_ff != 16'd0, "record data phase with no bytes left")
   `ZXF_ASSERT_IMPLY(a_disk_lane, clock, reset, wanted_ff == FLD_DISK || wanted_ff == FLD_NONE, fbi_ff[2] == 1'b0, "field byte index out of range for the field")

endmodule
`default_nettype wire

@@ hdl/zxf_result_reg.sv @@
`default_nettype none
module zxf_result_reg
   import zxf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  result_load_type load_req,
   input  logic            rsp_stall,
   output logic            free,
   output logic            rsp_valid,
   output result_type      result
);

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // A held word that is being taken this cycle frees the slot.
   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      data_in  = data_ff;
      if (load_req.load) begin
         valid_in = 1'b1;
         data_in  = load_req.result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign result    = data_ff;

endmodule
`default_nettype wire

@@ hdl/zip64_extra_field_parser.sv @@
`default_nettype none
// ZIP64 extended-information parser for one directory header's extra field.
// Input channel (req_): one extra-field byte per word, together with the
// header's 32-bit sizes, offset and 16-bit disk number; req_last_byte marks
// the final word. An empty extra field is one word with req_byte_present low
// and req_last_byte high. Result channel (rsp_): one word per header, carrying
// the resolved 64-bit sizes and offset, the 32-bit disk number, whether an
// id-1 record was found, and the parse status.
// Throughput is one input word per cycle while req_stall is low. A word is
// registered in the input register on acceptance and parsed from there; the
// result for a last word is then loaded into the output register.
// Synchronous reset empties both registers and returns the parser to the
// start of a record header. When rsp_stall holds a result, non-last words
// keep flowing; a last word waits in the input register, which then raises
// req_stall until the output register is free.
`include "zip64_extra_field_parser_assert.svh"
module zip64_extra_field_parser
   import zxf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_last_byte,
   input  logic [31:0] req_size_uncomp_short,
   input  logic [31:0] req_size_comp_short,
   input  logic [31:0] req_local_offset_short,
   input  logic [15:0] req_start_disk_short,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_uncomp_size,
   output logic [63:0] rsp_comp_size,
   output logic [63:0] rsp_local_offset,
   output logic [31:0] rsp_start_disk,
   output logic        rsp_record_found,
   output logic [1:0]  rsp_parse_status
);

   logic            in_valid_ff, in_valid_in;
   item_type        item_ff, item_in;
   logic            take;
   logic            fire;
   logic            out_free;
   result_type      parsed;
   result_load_type load_req;
   result_type      rsp_word;

   assign fire      = in_valid_ff && (!item_ff.last_byte || out_free);
   assign req_stall = in_valid_ff && !fire;
   assign take      = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff && !fire;
      item_in     = item_ff;
      if (take) begin
         in_valid_in            = 1'b1;
         item_in.data_byte          = req_data_byte;
         item_in.byte_present       = req_byte_present;
         item_in.last_byte          = req_last_byte;
         item_in.size_uncomp_short  = req_size_uncomp_short;
         item_in.size_comp_short    = req_size_comp_short;
         item_in.local_offset_short = req_local_offset_short;
         item_in.start_disk_short   = req_start_disk_short;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   zxf_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_ff),
      .result (parsed)
   );

   assign load_req.load   = fire && item_ff.last_byte;
   assign load_req.result = parsed;

   zxf_result_reg u_result_reg (
      .clock     (clock),
      .reset     (reset),
      .load_req  (load_req),
      .rsp_stall (rsp_stall),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .result    (rsp_word)
   );

   assign rsp_uncomp_size  = rsp_word.uncomp_size;
   assign rsp_comp_size    = rsp_word.comp_size;
   assign rsp_local_offset = rsp_word.local_offset;
   assign rsp_start_disk   = rsp_word.start_disk;
   assign rsp_record_found = rsp_word.record_found;
   assign rsp_parse_status = rsp_word.parse_status;

   `ZXF_ASSERT_IMPLY(a_load_slot_free, clock, reset, load_req.load, !(rsp_valid && rsp_stall), "result loaded over a stalled word")

endmodule
`default_nettype wire
